// File: rtl/mbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and codes for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // register indexes on the csr write channel
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MULTI_EN     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET       = 3'd6;

   localparam int CSR_DATA_W = 64;
   localparam int LEN_RAW_W  = 5;
   localparam int POS_W      = 32;

   typedef enum logic [1:0] {
      SCAN_NONE  = 2'd0,
      SCAN_OK    = 2'd1,
      SCAN_MULTI = 2'd2
   } scan_status_type;

   typedef struct packed {
      logic [63:0]          pattern_low;
      logic [63:0]          pattern_high;
      logic [63:0]          mask_low;
      logic [63:0]          mask_high;
      logic [LEN_RAW_W-1:0] pattern_length;
      logic                 multi_match_enable;
      logic [POS_W-1:0]     report_offset;
   } csr_cfg_type;

endpackage
`default_nettype wire

// File: rtl/mbps_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_csr
// Configuration register file, written over the csr channel.
// ----------------------------------------------------------------------------
module mbps_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mbps_pkg::CSR_DATA_W-1:0]    csr_data,
   output mbps_pkg::csr_cfg_type                   cfg
);
   import mbps_pkg::*;

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;
   logic        write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index)
            CSR_PATTERN_LOW:  cfg_in.pattern_low        = csr_data;
            CSR_PATTERN_HIGH: cfg_in.pattern_high       = csr_data;
            CSR_MASK_LOW:     cfg_in.mask_low           = csr_data;
            CSR_MASK_HIGH:    cfg_in.mask_high          = csr_data;
            CSR_PATTERN_LEN:  cfg_in.pattern_length     = csr_data[LEN_RAW_W-1:0];
            CSR_MULTI_EN:     cfg_in.multi_match_enable = csr_data[0];
            CSR_OFFSET:       cfg_in.report_offset      = csr_data[POS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pattern_low:        '0,
                     pattern_high:       '0,
                     mask_low:           '0,
                     mask_high:          '0,
                     pattern_length:     LEN_RAW_W'(1),
                     multi_match_enable: 1'b0,
                     report_offset:      '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: rtl/mbps_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_match
// Byte window and parallel masked compare of the pattern against it.
// ----------------------------------------------------------------------------
module mbps_match #(
   parameter int PATTERN_MAX = 16,
   parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  clear,
   input  wire logic [7:0]            data_byte,
   input  wire logic [LEN_W-1:0]      eff_len,
   input  wire mbps_pkg::csr_cfg_type cfg,
   output logic                       hit
);
   import mbps_pkg::*;

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [7:0]   window_ff [PATTERN_MAX];
   logic [7:0]   window_in [PATTERN_MAX];
   logic [7:0]   shifted   [PATTERN_MAX];
   logic [127:0] pat_all;
   logic [127:0] mask_all;

   assign pat_all  = {cfg.pattern_high, cfg.pattern_low};
   assign mask_all = {cfg.mask_high, cfg.mask_low};

   // entry 0 is the newest byte
   always_comb begin
      shifted[0] = data_byte;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         shifted[j] = window_ff[j-1];
      end
   end

   // pattern byte k lines up with window entry eff_len-1-k
   always_comb begin
      logic [LEN_W-1:0] idx;
      logic [7:0]       wb;
      hit = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         idx = eff_len - LEN_W'(1) - LEN_W'(k);
         wb  = shifted[idx[IDX_W-1:0]];
         if ((LEN_W'(k) < eff_len) &&
             (((pat_all[8*k +: 8] ^ wb) & mask_all[8*k +: 8]) != 8'd0)) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         window_in[j] = clear ? 8'd0 : shifted[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            window_ff[j] <= 8'd0;
         end
      end else if (advance) begin
         window_ff <= window_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Streams a buffer one byte per request and reports masked pattern matches.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one buffer byte per request, req_tlast on the final byte.
//   rsp_*  : a response for every reported match and for every final byte;
//            a final byte that also matches gives one response with both.
//   csr_*  : register writes (pattern, mask, length, multi-match, offset);
//            write only while no request is in flight. csr_ready is always 1.
// Each accepted request lands in an input register; when it advances it is
//   compared, updates the scan state and loads the response register.
//   Throughput: one request per cycle while the response side does not stall,
//   set by the single pass through the window compare and the 32-bit position adder.
// Reset: the registers take their defaults (length 1, all else zero), the
//   window and counters clear, and both channels come up empty.
// Stall: with a response held and rsp_tready low, a byte that would make a
//   response waits in the input register; bytes that make no response still
//   flow. req_tready drops only when the input register holds a stuck byte.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
   parameter int PATTERN_MAX = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  wire logic                              req_tlast,   // last_byte
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [39:0]                            rsp_tdata,   // [31:0] match_position,
                                                               // [33:32] scan_status,
                                                               // [39:34] zero
   output logic                                   rsp_tuser,   // match_found
   output logic                                   rsp_tlast,   // end_of_buffer
   // configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mbps_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mbps_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   csr_cfg_type cfg;

   // input register
   logic       a_valid_ff, a_valid_in;
   logic [7:0] a_data_ff;
   logic       a_last_ff;
   logic       a_advance;

   // scan state
   logic [POS_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic [1:0]       matches_seen_ff, matches_seen_in;
   logic             multi_error_ff, multi_error_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_end_ff;
   scan_status_type  rsp_status_ff;

   logic             hit;
   logic [LEN_W-1:0] eff_len;
   logic [POS_W-1:0] seen_inc;
   logic [POS_W-1:0] len_ext;
   logic             hit_ok;
   logic [1:0]       matches_inc;
   logic             report;
   logic             has_result;
   logic             out_free;
   logic [POS_W-1:0] match_pos;
   scan_status_type  status;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // clamp the length into 1..PATTERN_MAX
   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = LEN_W'(1);
      end else if (cfg.pattern_length > LEN_RAW_W'(PATTERN_MAX)) begin
         eff_len = LEN_W'(PATTERN_MAX);
      end else begin
         eff_len = LEN_W'(cfg.pattern_length);
      end
   end

   mbps_match #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .advance   (a_advance),
      .clear     (a_last_ff),
      .data_byte (a_data_ff),
      .eff_len   (eff_len),
      .cfg       (cfg),
      .hit       (hit)
   );

   // evaluate the byte in the input register against the updated window
   assign seen_inc    = bytes_seen_ff + POS_W'(1);
   assign len_ext     = POS_W'(eff_len);
   assign hit_ok      = (seen_inc >= len_ext) && hit && !multi_error_ff;
   assign matches_inc = (matches_seen_ff == 2'd3) ? 2'd3 : matches_seen_ff + 2'd1;
   assign match_pos   = seen_inc - len_ext + cfg.report_offset;

   always_comb begin
      matches_seen_in = matches_seen_ff;
      multi_error_in  = multi_error_ff;
      report          = 1'b0;
      if (hit_ok) begin
         matches_seen_in = matches_inc;
         if (!cfg.multi_match_enable && (matches_inc > 2'd1)) begin
            multi_error_in = 1'b1;
         end else begin
            report = 1'b1;
         end
      end
      if (multi_error_in) begin
         status = SCAN_MULTI;
      end else if (matches_seen_in != 2'd0) begin
         status = SCAN_OK;
      end else begin
         status = SCAN_NONE;
      end
      bytes_seen_in = seen_inc;
   end

   assign has_result = report || a_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign a_advance  = a_valid_ff && (!has_result || out_free);
   assign req_tready = !a_valid_ff || a_advance;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_tvalid && req_tready) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (a_advance && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         bytes_seen_ff   <= '0;
         matches_seen_ff <= '0;
         multi_error_ff  <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (a_advance) begin
            // drop the scan state once the buffer closes
            bytes_seen_ff   <= a_last_ff ? '0   : bytes_seen_in;
            matches_seen_ff <= a_last_ff ? 2'd0 : matches_seen_in;
            multi_error_ff  <= a_last_ff ? 1'b0 : multi_error_in;
         end
      end
   end

   // payload: hold the request byte, load the response on advance
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_data_ff <= req_tdata;
         a_last_ff <= req_tlast;
      end
      if (a_advance && has_result) begin
         rsp_found_ff  <= report;
         rsp_pos_ff    <= report ? match_pos : '0;
         rsp_end_ff    <= a_last_ff;
         rsp_status_ff <= a_last_ff ? status : SCAN_NONE;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_pos_ff};

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   // a response without a match carries position zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("non-match response with nonzero position");

   // only a closing response carries a status, and never the unused code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tlast || (rsp_tdata[33:32] == 2'd0)) &&
                      (rsp_tdata[33:32] != 2'd3)))
      else $error("bad scan status on response");

   // the multiple-match error only follows at least two matches
   assert property (@(posedge clock) disable iff (reset)
      multi_error_ff |-> (matches_seen_ff >= 2'd2))
      else $error("multi-match error without a second match");

   // the scan state clears after the closing byte advances
   assert property (@(posedge clock) disable iff (reset)
      (a_advance && a_last_ff) |=>
         ((bytes_seen_ff == '0) && (matches_seen_ff == 2'd0) && !multi_error_ff))
      else $error("scan state not cleared at end of buffer");

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the masked byte pattern scanner. Bytes stream in
// as buffers; a shadow scanner in the bench predicts every match report and
// buffer-close status, and the responses are scored field by field in order.
// A short directed table opens the run, then random buffers under randomly
// chosen pattern, mask, length, multi-match and offset settings follow.
// ----------------------------------------------------------------------------
module tb;
   import mbps_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for backpressure
   localparam int SETTLE       = 4;     // cycles to let a non-reporting byte drain
   localparam int WINDOW_MAX   = 16;

   // one response as the scanner should deliver it
   typedef struct packed {
      logic            match_found;
      logic [31:0]     match_position;
      logic            end_of_buffer;
      scan_status_type scan_status;
   } scan_report_t;

   // one row of the directed table: a register write or a buffer byte
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] csr_index;
      logic [CSR_DATA_W-1:0]  csr_value;
      logic [7:0]             data_byte;
      logic                   last_byte;
      bit                     typed;     // response given in the row itself
      scan_report_t           want;
   } stim_row_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] data_byte
   logic                   req_tlast;   // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [39:0]            rsp_tdata;   // [31:0] match_position, [33:32] scan_status,
                                        // [39:34] zero
   logic                   rsp_tuser;   // match_found
   logic                   rsp_tlast;   // end_of_buffer
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // shadow registers
   logic [63:0] cfg_pattern_low;
   logic [63:0] cfg_pattern_high;
   logic [63:0] cfg_mask_low;
   logic [63:0] cfg_mask_high;
   logic [4:0]  cfg_length_raw;
   logic        cfg_multi_enable;
   logic [31:0] cfg_offset;

   // shadow scan state
   logic [7:0]  scan_window [WINDOW_MAX];
   logic [31:0] bytes_seen;
   int unsigned matches_seen;
   bit          multi_error;

   scan_report_t pending_reports [$];
   stim_row_t    directed_rows [$];
   int           mismatch_count = 0;
   int           random_items = 0;
   bit           steady_traffic = 1'b0;   // no idling on either side while set
   bit           hold_off_request = 1'b0; // main asks, receiver clears

   masked_byte_pattern_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshakes lock up
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // -------------------------------------------------------------------------
   // shadow scanner
   // -------------------------------------------------------------------------
   function automatic logic [7:0] byte_of(input logic [127:0] lanes, input int unsigned k);
      return lanes[8*k +: 8];
   endfunction

   // length 0 counts as 1, anything past the window counts as the full window
   function automatic int unsigned effective_length();
      int unsigned n;
      n = cfg_length_raw;
      if (n == 0) n = 1;
      if (n > WINDOW_MAX) n = WINDOW_MAX;
      return n;
   endfunction

   task automatic clear_scan();
      foreach (scan_window[k]) scan_window[k] = 8'h00;
      bytes_seen   = '0;
      matches_seen = 0;
      multi_error  = 1'b0;
   endtask

   task automatic restore_defaults();
      cfg_pattern_low  = '0;
      cfg_pattern_high = '0;
      cfg_mask_low     = '0;
      cfg_mask_high    = '0;
      cfg_length_raw   = 5'd1;
      cfg_multi_enable = 1'b0;
      cfg_offset       = '0;
      clear_scan();
   endtask

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PATTERN_LOW:  cfg_pattern_low  = value;
         CSR_PATTERN_HIGH: cfg_pattern_high = value;
         CSR_MASK_LOW:     cfg_mask_low     = value;
         CSR_MASK_HIGH:    cfg_mask_high    = value;
         CSR_PATTERN_LEN:  cfg_length_raw   = value[4:0];
         CSR_MULTI_EN:     cfg_multi_enable = value[0];
         CSR_OFFSET:       cfg_offset       = value[31:0];
         default: ;
      endcase
   endtask

   // advance the shadow by one accepted byte; emit says whether a response follows
   task automatic scan_step(input logic [7:0] data_byte, input logic last_byte,
                            output bit emit, output scan_report_t rpt);
      int unsigned len;
      bit          hit;
      logic [7:0]  pat;
      logic [7:0]  msk;
      logic [7:0]  seen;
      len = effective_length();
      rpt = '0;
      for (int k = WINDOW_MAX - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
      scan_window[0] = data_byte;
      bytes_seen = bytes_seen + 32'd1;
      if (bytes_seen >= len) begin
         hit = 1'b1;
         // pattern byte k lines up with the byte k places after the start
         for (int unsigned k = 0; k < len; k++) begin
            pat  = byte_of({cfg_pattern_high, cfg_pattern_low}, k);
            msk  = byte_of({cfg_mask_high, cfg_mask_low}, k);
            seen = scan_window[len - 1 - k];
            if (((pat ^ seen) & msk) != 8'h00) hit = 1'b0;
         end
         if (hit && !multi_error) begin
            if (matches_seen < 3) matches_seen++;
            if (!cfg_multi_enable && matches_seen > 1) begin
               multi_error = 1'b1;
            end else begin
               rpt.match_found    = 1'b1;
               rpt.match_position = bytes_seen - 32'(len) + cfg_offset;
            end
         end
      end
      emit = rpt.match_found || last_byte;
      if (last_byte) begin
         rpt.end_of_buffer = 1'b1;
         rpt.scan_status   = multi_error ? SCAN_MULTI :
                             (matches_seen > 0 ? SCAN_OK : SCAN_NONE);
         clear_scan();
      end
   endtask

   // -------------------------------------------------------------------------
   // drivers: inputs move on the falling edge, handshakes seen on the rising
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] data_byte, input logic last_byte,
                            input bit typed, input scan_report_t want);
      bit           emit;
      scan_report_t rpt;
      // random gaps between requests
      while (!steady_traffic && $urandom_range(0, 99) < 29) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tlast  <= last_byte;
      do @(posedge clock); while (!req_tready);
      scan_step(data_byte, last_byte, emit, rpt);
      if (typed) pending_reports.push_back(want);
      else if (emit) pending_reports.push_back(rpt);
   endtask

   // drop the request line, drain every expected response, then let the
   // input register empty out before touching the registers
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // directed table
   // -------------------------------------------------------------------------
   task automatic add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      stim_row_t row;
      row = '{default: '0};
      row.is_csr    = 1'b1;
      row.csr_index = idx;
      row.csr_value = value;
      directed_rows.push_back(row);
   endtask

   task automatic add_byte(input logic [7:0] data_byte, input logic last_byte);
      stim_row_t row;
      row = '{default: '0};
      row.data_byte = data_byte;
      row.last_byte = last_byte;
      directed_rows.push_back(row);
   endtask

   task automatic add_checked(input logic [7:0] data_byte, input logic last_byte,
                              input logic found, input logic [31:0] position,
                              input logic closes, input scan_status_type status);
      stim_row_t row;
      row = '{default: '0};
      row.data_byte = data_byte;
      row.last_byte = last_byte;
      row.typed     = 1'b1;
      row.want      = '{found, position, closes, status};
      directed_rows.push_back(row);
   endtask

   task automatic build_directed_table();
      // reset settings: length 1 with an empty mask, so every byte matches
      add_checked(8'h00, 1'b0, 1'b1, 32'h0, 1'b0, SCAN_NONE);
      // second match with multi-match off: swallowed, buffer closes in error
      add_checked(8'hFF, 1'b1, 1'b0, 32'h0, 1'b1, SCAN_MULTI);
      // one-byte buffer: match and close on the same response
      add_checked(8'hA5, 1'b1, 1'b1, 32'h0, 1'b1, SCAN_OK);
      // full-width exact pattern 00..0F, largest offset
      add_csr(CSR_PATTERN_LOW,  64'h0706_0504_0302_0100);
      add_csr(CSR_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908);
      add_csr(CSR_MASK_LOW,     '1);
      add_csr(CSR_MASK_HIGH,    '1);
      add_csr(CSR_PATTERN_LEN,  64'd16);
      add_csr(CSR_MULTI_EN,     64'd1);
      add_csr(CSR_OFFSET,       64'hFFFF_FFFF);
      for (int i = 0; i < 15; i++) add_byte(8'(i), 1'b0);
      // final window position ends on the last byte; start 0 + offset gives FFFF_FFFF
      add_checked(8'h0F, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, SCAN_OK);
      // buffer shorter than the pattern
      add_byte(8'h00, 1'b0);
      add_checked(8'h01, 1'b1, 1'b0, 32'h0, 1'b1, SCAN_NONE);
      // length 0 behaves as length 1
      add_csr(CSR_PATTERN_LEN, 64'd0);
      add_checked(8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, SCAN_OK);
   endtask

   // -------------------------------------------------------------------------
   // random settings and buffers
   // -------------------------------------------------------------------------
   function automatic logic [63:0] pick_pattern();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_mask();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 40) return '1;
      if (r < 80) return {$urandom, $urandom};
      return {$urandom, $urandom} & {$urandom, $urandom};   // sparse
   endfunction

   function automatic logic [63:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 64'($urandom_range(1, 4));
      if (r < 70) return 64'($urandom_range(5, 15));
      if (r < 80) return 64'd16;
      if (r < 88) return 64'($urandom_range(17, 31));
      if (r < 94) return 64'd0;
      return 64'd1;
   endfunction

   function automatic logic [63:0] pick_offset();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return 64'd0;
      if (r < 35) return 64'hFFFF_FFFF;
      if (r < 50) return 64'(32'hFFFF_FFF0 + $urandom_range(0, 15));
      return 64'($urandom);
   endfunction

   task automatic randomize_config();
      write_register(CSR_PATTERN_LOW,  pick_pattern());
      write_register(CSR_PATTERN_HIGH, pick_pattern());
      write_register(CSR_MASK_LOW,     pick_mask());
      write_register(CSR_MASK_HIGH,    pick_mask());
      write_register(CSR_PATTERN_LEN,  pick_length());
      write_register(CSR_MULTI_EN,     64'($urandom_range(0, 1)));
      write_register(CSR_OFFSET,       pick_offset());
   endtask

   // one buffer: mostly noise with planted pattern copies, some plain noise,
   // some short or with one planted copy broken in a masked bit
   task automatic send_buffer();
      logic [7:0]  stream_bytes [];
      logic [7:0]  msk;
      int unsigned len;
      int unsigned total;
      int unsigned style;
      int unsigned start;
      int unsigned k;
      len   = effective_length();
      style = $urandom_range(0, 99);
      start = 0;
      if (style < 70) total = $urandom_range(len, 2 * len + 12);
      else if (style < 85) total = $urandom_range(1, 24);
      else total = $urandom_range(1, len + 4);
      stream_bytes = new[total];
      foreach (stream_bytes[i]) stream_bytes[i] = 8'($urandom_range(0, 255));
      if ((style < 70 || style >= 85) && total >= len) begin
         repeat ($urandom_range(1, 3)) begin
            // favor the window that ends on the last byte
            start = ($urandom_range(0, 3) == 0) ? total - len : $urandom_range(0, total - len);
            for (int unsigned j = 0; j < len; j++) begin
               msk = byte_of({cfg_mask_high, cfg_mask_low}, j);
               stream_bytes[start + j] = (byte_of({cfg_pattern_high, cfg_pattern_low}, j) & msk)
                                       | (8'($urandom_range(0, 255)) & ~msk);
            end
         end
         if (style >= 85) begin
            // flip the lowest cared-about bit of one byte of the last copy
            k   = $urandom_range(0, len - 1);
            msk = byte_of({cfg_mask_high, cfg_mask_low}, k);
            stream_bytes[start + k] = stream_bytes[start + k] ^ (msk & (~msk + 8'd1));
         end
      end
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == total - 1, 1'b0, '0);
      random_items += total;
   endtask

   // -------------------------------------------------------------------------
   // receiver: random stalls, one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (steady_traffic) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // -------------------------------------------------------------------------
   // scoreboard: compare each accepted response with the oldest expectation
   // -------------------------------------------------------------------------
   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      scan_report_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("response with no request pending");
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("match_found", 32'(want.match_found), 32'(rsp_tuser));
            compare_field("match_position", want.match_position, rsp_tdata[31:0]);
            compare_field("end_of_buffer", 32'(want.end_of_buffer), 32'(rsp_tlast));
            compare_field("scan_status", 32'(want.scan_status), 32'(rsp_tdata[33:32]));
         end
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      bit prev_csr;
      int phase;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      restore_defaults();
      build_directed_table();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table; register rows only once the block is quiet
      prev_csr = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            if (!prev_csr) wait_quiet();
            write_register(directed_rows[i].csr_index, directed_rows[i].csr_value);
         end else begin
            send_byte(directed_rows[i].data_byte, directed_rows[i].last_byte,
                      directed_rows[i].typed, directed_rows[i].want);
         end
         prev_csr = directed_rows[i].is_csr;
      end

      // random phases: new settings, then a handful of buffers
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_quiet();
         steady_traffic = (phase >= 6 && phase < 9);
         if (phase == 3) begin
            // every byte reports: hold the receiver so the block backs up
            write_register(CSR_MASK_LOW,    '0);
            write_register(CSR_MASK_HIGH,   '0);
            write_register(CSR_PATTERN_LEN, 64'd1);
            write_register(CSR_MULTI_EN,    64'd1);
            hold_off_request = 1'b1;
            for (int i = 0; i < 48; i++) send_byte(8'($urandom_range(0, 255)), i == 47, 1'b0, '0);
            random_items += 48;
         end else begin
            randomize_config();
            repeat ($urandom_range(2, 6)) send_buffer();
         end
         phase++;
      end
      steady_traffic = 1'b0;

      // drain, then let the pipeline settle
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/mbps_pkg.sv
rtl/mbps_csr.sv
rtl/mbps_match.sv
rtl/masked_byte_pattern_scanner.sv
test/tb.sv
